### rtl/u8u16_pkg.sv
package u8u16_pkg;

  // Maximum number of UTF-16 units that one string may produce.
  localparam int UNIT_CAPACITY = 2048;
  localparam int COUNT_W       = 12;
  localparam int POINT_W       = 21;
  localparam int UNIT_W        = 16;

  // Depth of the command queue between the front and the back part.
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam logic [COUNT_W-1:0] CAPACITY    = COUNT_W'(UNIT_CAPACITY);
  localparam logic [COUNT_W:0]   CAPACITY_X  = (COUNT_W + 1)'(UNIT_CAPACITY);
  localparam logic [POINT_W-1:0] SUPPLEMENT  = POINT_W'(32'h10000);
  localparam logic [5:0]         HIGH_SURR   = 6'b110110;  // 0xD800 >> 10
  localparam logic [5:0]         LOW_SURR    = 6'b110111;  // 0xDC00 >> 10

  // Lead byte classes.
  typedef enum logic [1:0] {
    LEAD_ONE   = 2'd0,
    LEAD_TWO   = 2'd1,
    LEAD_THREE = 2'd2,
    LEAD_FOUR  = 2'd3
  } lead_class_t;

  // One command: up to two code units, optionally followed by an end record.
  typedef struct packed {
    logic [UNIT_W-1:0]  unit_first;
    logic [UNIT_W-1:0]  unit_second;
    logic [1:0]         num_units;
    logic               has_end;
    logic               overflow;
    logic [COUNT_W-1:0] count;
  } cmd_t;

  function automatic lead_class_t classify(input logic [7:0] b);
    lead_class_t c;
    c = LEAD_FOUR;
    if (b < 8'h80) begin
      c = LEAD_ONE;
    end else if (b < 8'hE0) begin
      c = LEAD_TWO;
    end else if (b < 8'hF0) begin
      c = LEAD_THREE;
    end
    return c;
  endfunction

endpackage

### rtl/u8u16_front.sv
module u8u16_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_ready,
  input  logic [7:0]        byte_in,
  input  logic              last_byte,
  output logic              push,
  output u8u16_pkg::cmd_t   cmd,
  input  logic              queue_full
);

  logic [u8u16_pkg::POINT_W-1:0] partial_point, partial_point_next;
  logic [1:0]                    bytes_pending, bytes_pending_next;
  logic [2:0]                    sequence_length, sequence_length_next;
  logic [u8u16_pkg::COUNT_W-1:0] units_emitted, units_emitted_next;
  logic                          overflowed, overflowed_next;

  logic                          accept;
  logic [u8u16_pkg::POINT_W-1:0] shifted;
  logic [u8u16_pkg::POINT_W-1:0] offset;
  u8u16_pkg::lead_class_t        lead;

  assign byte_ready = !queue_full;
  assign accept     = byte_valid && byte_ready;
  assign lead       = u8u16_pkg::classify(byte_in);
  assign shifted    = {partial_point[u8u16_pkg::POINT_W-7:0], byte_in[5:0]};
  assign offset     = shifted - u8u16_pkg::SUPPLEMENT;

  always_comb begin
    partial_point_next   = partial_point;
    bytes_pending_next   = bytes_pending;
    sequence_length_next = sequence_length;
    overflowed_next      = overflowed;
    cmd                  = '0;

    if (overflowed) begin
      // The rest of the string is dropped.
    end else if (bytes_pending == 2'd0) begin
      if (units_emitted >= u8u16_pkg::CAPACITY) begin
        overflowed_next = 1'b1;
      end else begin
        case (lead)
          u8u16_pkg::LEAD_ONE: begin
            cmd.unit_first = {8'h00, byte_in};
            cmd.num_units  = 2'd1;
          end
          u8u16_pkg::LEAD_TWO: begin
            partial_point_next   = u8u16_pkg::POINT_W'(byte_in[4:0]);
            bytes_pending_next   = 2'd1;
            sequence_length_next = 3'd2;
          end
          u8u16_pkg::LEAD_THREE: begin
            partial_point_next   = u8u16_pkg::POINT_W'(byte_in[3:0]);
            bytes_pending_next   = 2'd2;
            sequence_length_next = 3'd3;
          end
          default: begin
            // A pair needs room for two units.
            if ({1'b0, units_emitted} + 13'd1 >= u8u16_pkg::CAPACITY_X) begin
              overflowed_next = 1'b1;
            end else begin
              partial_point_next   = u8u16_pkg::POINT_W'(byte_in[2:0]);
              bytes_pending_next   = 2'd3;
              sequence_length_next = 3'd4;
            end
          end
        endcase
      end
    end else begin
      partial_point_next = shifted;
      bytes_pending_next = bytes_pending - 2'd1;
      if (bytes_pending == 2'd1) begin
        if (sequence_length == 3'd4) begin
          cmd.unit_first  = {u8u16_pkg::HIGH_SURR, offset[19:10]};
          cmd.unit_second = {u8u16_pkg::LOW_SURR, offset[9:0]};
          cmd.num_units   = 2'd2;
        end else begin
          cmd.unit_first = shifted[15:0];
          cmd.num_units  = 2'd1;
        end
        partial_point_next   = '0;
        sequence_length_next = '0;
      end
    end

    units_emitted_next = units_emitted + u8u16_pkg::COUNT_W'(cmd.num_units);
    cmd.has_end        = last_byte;
    cmd.overflow       = last_byte & overflowed_next;
    cmd.count          = last_byte ? units_emitted_next : '0;
  end

  assign push = accept && ((cmd.num_units != 2'd0) || last_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_point   <= '0;
      bytes_pending   <= '0;
      sequence_length <= '0;
      units_emitted   <= '0;
      overflowed      <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        partial_point   <= '0;
        bytes_pending   <= '0;
        sequence_length <= '0;
        units_emitted   <= '0;
        overflowed      <= 1'b0;
      end else begin
        partial_point   <= partial_point_next;
        bytes_pending   <= bytes_pending_next;
        sequence_length <= sequence_length_next;
        units_emitted   <= units_emitted_next;
        overflowed      <= overflowed_next;
      end
    end
  end

endmodule

### rtl/u8u16_queue.sv
module u8u16_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u8u16_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output u8u16_pkg::cmd_t head_cmd
);

  u8u16_pkg::cmd_t                entries [u8u16_pkg::QUEUE_DEPTH];
  logic [u8u16_pkg::QPTR_W-1:0]   wr_ptr;
  logic [u8u16_pkg::QPTR_W-1:0]   rd_ptr;
  logic [u8u16_pkg::QPTR_W:0]     fill;

  assign full       = (fill == (u8u16_pkg::QPTR_W + 1)'(u8u16_pkg::QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("command pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && !head_valid))
    else $error("command popped from an empty queue");
  a_fill_tracks: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (fill == $past(fill) + 1'b1))
    else $error("queue fill count lost a push");

endmodule

### rtl/u8u16_back.sv
module u8u16_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  u8u16_pkg::cmd_t   head_cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [u8u16_pkg::UNIT_W-1:0]  code_unit,
  output logic              unit_valid,
  output logic              end_of_string,
  output logic              overflow_error,
  output logic [u8u16_pkg::COUNT_W-1:0] unit_count
);

  logic [1:0] sub;
  logic [1:0] total;
  logic       last_rec;
  logic       load;
  logic       is_first;
  logic       is_second;

  assign total     = head_cmd.num_units + {1'b0, head_cmd.has_end};
  assign last_rec  = (sub == total - 2'd1);
  assign load      = head_valid && (!out_valid || out_ready);
  assign pop       = load && last_rec;
  assign is_first  = (sub == 2'd0) && (head_cmd.num_units != 2'd0);
  assign is_second = (sub == 2'd1) && (head_cmd.num_units == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      sub       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        sub <= last_rec ? 2'd0 : sub + 2'd1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (is_first || is_second) begin
        code_unit      <= is_first ? head_cmd.unit_first : head_cmd.unit_second;
        unit_valid     <= 1'b1;
        end_of_string  <= 1'b0;
        overflow_error <= 1'b0;
        unit_count     <= '0;
      end else begin
        code_unit      <= '0;
        unit_valid     <= 1'b0;
        end_of_string  <= 1'b1;
        overflow_error <= head_cmd.overflow;
        unit_count     <= head_cmd.count;
      end
    end
  end

endmodule

### rtl/utf8_to_utf16_stream_decoder_unit.sv
// Channel | Direction | Beat contents
// s_axis  | in        | tdata[7:0] UTF-8 byte, tlast marks the last byte of a string
// m_axis  | out       | tdata code unit, overflow flag, unit count; tuser unit flag;
//         |           | tlast marks the end record of a string
//
// A byte is taken every cycle while the four-entry command queue has room.
// Single-unit characters leave at one beat per cycle; a surrogate pair takes
// two output beats and an end record one more, so the output register sets
// the rate at one beat per cycle while m_axis_tready is high, and bytes
// wait only when the queue fills. Commands pass through the queue before
// their beats reach the output register. rst is synchronous and active
// high; it clears the decode state, the queue and the output register.
module utf8_to_utf16_stream_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] code_unit, [16] overflow_error,
                                      // [28:17] unit_count, [31:29] zero
  output logic        m_axis_tuser,   // unit_valid
  output logic        m_axis_tlast    // end_of_string
);

  logic            push;
  logic            pop;
  logic            queue_full;
  logic            head_valid;
  u8u16_pkg::cmd_t push_cmd;
  u8u16_pkg::cmd_t head_cmd;

  logic [u8u16_pkg::UNIT_W-1:0]  code_unit;
  logic                          overflow_error;
  logic [u8u16_pkg::COUNT_W-1:0] unit_count;

  // The front part decodes each byte into at most one command holding the
  // units and end record that byte causes.
  u8u16_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (s_axis_tvalid),
    .byte_ready (s_axis_tready),
    .byte_in    (s_axis_tdata),
    .last_byte  (s_axis_tlast),
    .push       (push),
    .cmd        (push_cmd),
    .queue_full (queue_full)
  );

  // The queue lets the byte side keep going while a pair or end record is
  // still being sent out.
  u8u16_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // The back part expands each command into one beat per record.
  u8u16_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_cmd       (head_cmd),
    .pop            (pop),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .code_unit      (code_unit),
    .unit_valid     (m_axis_tuser),
    .end_of_string  (m_axis_tlast),
    .overflow_error (overflow_error),
    .unit_count     (unit_count)
  );

  assign m_axis_tdata = {3'b000, unit_count, overflow_error, code_unit};

endmodule

### bench/utf16_unit_checker.sv
module utf16_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          records_pending,
  output int          mismatch_total
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [u8u16_pkg::UNIT_W-1:0]  code_unit;
    logic                          unit_valid;
    logic                          end_of_string;
    logic                          overflow_error;
    logic [u8u16_pkg::COUNT_W-1:0] unit_count;
  } utf16_record_t;

  utf16_record_t expected_units[$];
  int mismatches = 0;

  // Decoder state as the block should hold it.
  logic [u8u16_pkg::POINT_W-1:0] partial_point   = '0;
  logic [1:0]                    bytes_pending   = '0;
  logic [2:0]                    seq_len         = '0;
  logic [u8u16_pkg::COUNT_W-1:0] units_emitted   = '0;
  logic                          overflowed      = 1'b0;

  task automatic clear_decoder();
    partial_point = '0;
    bytes_pending = '0;
    seq_len       = '0;
    units_emitted = '0;
    overflowed    = 1'b0;
  endtask

  task automatic push_unit(input logic [u8u16_pkg::UNIT_W-1:0] unit);
    expected_units.push_back('{unit, 1'b1, 1'b0, 1'b0, '0});
    units_emitted = units_emitted + 1'b1;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic [u8u16_pkg::POINT_W-1:0] offset;
    if (overflowed) begin
      // The rest of an overflowed string is thrown away.
    end else if (bytes_pending == 0) begin
      if (int'(units_emitted) >= u8u16_pkg::UNIT_CAPACITY) begin
        overflowed = 1'b1;
      end else if (b < 8'h80) begin
        push_unit({8'h00, b});
      end else if (b < 8'hE0) begin
        partial_point = u8u16_pkg::POINT_W'(b & 8'h1F);
        bytes_pending = 2'd1;
        seq_len       = 3'd2;
      end else if (b < 8'hF0) begin
        partial_point = u8u16_pkg::POINT_W'(b & 8'h0F);
        bytes_pending = 2'd2;
        seq_len       = 3'd3;
      end else if (int'(units_emitted) + 1 >= u8u16_pkg::UNIT_CAPACITY) begin
        // A surrogate pair needs two free units.
        overflowed = 1'b1;
      end else begin
        partial_point = u8u16_pkg::POINT_W'(b & 8'h07);
        bytes_pending = 2'd3;
        seq_len       = 3'd4;
      end
    end else begin
      partial_point = {partial_point[u8u16_pkg::POINT_W-7:0], b[5:0]};
      bytes_pending = bytes_pending - 2'd1;
      if (bytes_pending == 0) begin
        if (seq_len == 3'd4) begin
          offset = partial_point - u8u16_pkg::SUPPLEMENT;
          push_unit({u8u16_pkg::HIGH_SURR, offset[19:10]});
          push_unit({u8u16_pkg::LOW_SURR, offset[9:0]});
        end else begin
          push_unit(partial_point[u8u16_pkg::UNIT_W-1:0]);
        end
        partial_point = '0;
        seq_len       = '0;
      end
    end
    if (last) begin
      expected_units.push_back('{'0, 1'b0, 1'b1, overflowed, units_emitted});
      clear_decoder();
    end
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    utf16_record_t want;
    if (rst) begin
      clear_decoder();
      expected_units.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_units.size() == 0) begin
          $error("output beat with nothing expected, tdata 0x%0h", m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_units.pop_front();
          compare_field("code_unit", want.code_unit, m_axis_tdata[15:0]);
          compare_field("overflow_error", want.overflow_error, m_axis_tdata[16]);
          compare_field("unit_count", want.unit_count, m_axis_tdata[28:17]);
          compare_field("tdata padding", 0, m_axis_tdata[31:29]);
          compare_field("unit_valid", want.unit_valid, m_axis_tuser);
          compare_field("end_of_string", want.end_of_string, m_axis_tlast);
        end
      end
    end
    records_pending <= expected_units.size();
    mismatch_total  <= mismatches;
  end

endmodule

### bench/utf8_to_utf16_stream_decoder_unit_test.sv
module utf8_to_utf16_stream_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // The slowest legal run is roughly four hundred and fifty bytes, each
  // causing at most three output beats with the receiver ready less than a
  // third of the time, so this limit is ample.
  localparam int CYCLE_LIMIT = 400_000;

  // Length of the one long receiver hold-off, in cycles.
  localparam int HOLD_OFF_CYCLES = 400;

  // Hand-picked strings. Bit 8 is the last-byte flag, bits 7:0 the byte.
  localparam logic [8:0] DIRECTED [26] = '{
    9'h141,                          // a single ASCII character
    9'h000, 9'h17F,                  // lowest and highest ASCII values
    9'h0C3, 9'h1A9,                  // two-byte character
    9'h0DF, 9'h1BF,                  // largest two-byte character
    9'h0E2, 9'h082, 9'h1AC,          // three-byte character
    9'h0EF, 9'h0BF, 9'h1BF,          // largest three-byte character
    9'h0F0, 9'h09F, 9'h098, 9'h180,  // four-byte character, a surrogate pair
    9'h0FF, 9'h0FF, 9'h0FF, 9'h1FF,  // all-ones sequence, the point wraps
    9'h0E2, 9'h182,                  // string ends inside a character
    9'h1F4,                          // a lone four-byte lead ends the string
    9'h080, 9'h1BF                   // a continuation byte taken as a lead
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // Idle rates in percent for each side, changed between phases.
  int          send_idle_pct = 34;
  int          recv_idle_pct = 70;

  // Asks the receiver for its one long hold-off.
  logic        hold_request  = 1'b0;
  logic        hold_taken    = 1'b0;
  int          hold_left     = 0;

  int          records_pending;
  int          mismatch_total;
  int          cycle_count   = 0;

  always #5 clk = ~clk;

  utf8_to_utf16_stream_decoder_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // The checker watches both channels, predicts every record and counts
  // mismatches; this module only makes stimulus and gives the verdict.
  utf16_unit_checker checker_inst (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tlast    (s_axis_tlast),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .m_axis_tlast    (m_axis_tlast),
    .records_pending (records_pending),
    .mismatch_total  (mismatch_total)
  );

  // Receiver side. It stalls at random, and once, when asked, it holds off for
  // a long stretch so that the command queue fills and the input stalls.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_request && !hold_taken) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_OFF_CYCLES;
      hold_taken    <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: a run that hangs ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offers one byte, after a random gap, and returns at the edge where the
  // beat is taken. The valid line is assigned at most once per edge.
  task automatic send_beat(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Random strings, mostly well-formed UTF-8 with random content. Some
  // characters are noise bytes or carry a bad continuation byte, and some
  // strings are cut off in the middle of a character.
  task automatic send_random_text(input int budget);
    logic [7:0] text[$];
    logic [7:0] lead;
    int         sent;
    int         chars;
    int         kind;
    int         extra;
    int         cut;
    sent = 0;
    while (sent < budget) begin
      text.delete();
      chars = $urandom_range(1, 10);
      repeat (chars) begin
        kind = $urandom_range(0, 9);
        case (kind)
          4, 5: begin
            lead  = ($urandom_range(3) == 0) ? 8'($urandom_range(8'h80, 8'hDF))
                                             : 8'($urandom_range(8'hC2, 8'hDF));
            extra = 1;
          end
          6, 7: begin
            lead  = 8'($urandom_range(8'hE0, 8'hEF));
            extra = 2;
          end
          8: begin
            lead  = ($urandom_range(3) == 0) ? 8'($urandom_range(8'hF0, 8'hFF))
                                             : 8'($urandom_range(8'hF0, 8'hF4));
            extra = 3;
          end
          9: begin
            lead  = 8'($urandom);
            extra = $urandom_range(0, 3);
          end
          default: begin
            lead  = 8'($urandom_range(0, 127));
            extra = 0;
          end
        endcase
        text.push_back(lead);
        repeat (extra) begin
          text.push_back(($urandom_range(9) == 0) ? 8'($urandom)
                                                  : 8'($urandom_range(8'h80, 8'hBF)));
        end
      end
      // Now and then the string loses up to three bytes from its end, which may leave it inside a character.
      if ($urandom_range(7) == 0 && text.size() > 1) begin
        cut = $urandom_range(1, (text.size() > 3) ? 3 : text.size() - 1);
        repeat (cut) void'(text.pop_back());
      end
      foreach (text[i]) send_beat(text[i], i == text.size() - 1);
      sent += text.size();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // First phase: the sender idles about a third of the time and the
    // receiver most of the time.
    foreach (DIRECTED[i]) send_beat(DIRECTED[i][7:0], DIRECTED[i][8]);

    send_random_text(135);

    // Second phase: the roles swap.
    send_idle_pct = 70;
    recv_idle_pct <= 34;
    send_random_text(135);

    // Third phase: no idling. The receiver first holds off for a long time
    // while the sender keeps offering bytes.
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_request  <= 1'b1;
    send_random_text(115);
    s_axis_tvalid <= 1'b0;

    // Let the last beat reach the checker, drain, then watch a few more edges
    // for stray output beats.
    @(posedge clk);
    while (records_pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (mismatch_total == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
rtl/u8u16_pkg.sv
rtl/u8u16_front.sv
rtl/u8u16_queue.sv
rtl/u8u16_back.sv
rtl/utf8_to_utf16_stream_decoder_unit.sv
bench/utf16_unit_checker.sv
bench/utf8_to_utf16_stream_decoder_unit_test.sv
